// ===== rtl/core/icmp_probe_reply_classifier_top_assert.svh =====
// ----------------------------------------------------------------------------
// ICMP probe reply classifier assertion macros
// Short forms for same-cycle and next-cycle checks, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ICMP_PROBE_REPLY_CLASSIFIER_TOP_ASSERT_SVH
`define ICMP_PROBE_REPLY_CLASSIFIER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICMP_PRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICMP_PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/icmp_prc_pkg.sv =====
// ----------------------------------------------------------------------------
// ICMP probe reply classifier package
// Shared widths, codes and types of the classifier.
// ----------------------------------------------------------------------------
package icmp_prc_pkg;

	localparam int MAX_PACKET_BYTES = 1024;
	// Byte counter holds the saturated packet length itself
	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IP_VERSION  = 1'b0,
		REG_PROBE_IDENT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_HOP  = 2'd1,
		KIND_DEST = 2'd2
	} reply_kind_t;

	localparam logic [7:0] V4_ECHO_REPLY = 8'd0;
	localparam logic [7:0] V4_TIME_EXCEEDED = 8'd11;
	localparam logic [7:0] V6_ECHO_REPLY = 8'd129;
	localparam logic [7:0] V6_TIME_EXCEEDED = 8'd3;

	// Fixed ICMPv6 offsets
	localparam logic [7:0] V6_IDENT_OFF = 8'd4;
	localparam logic [7:0] V6_SEQ_OFF = 8'd6;
	localparam logic [7:0] V6_INNER_IDENT_OFF = 8'd52;
	localparam logic [7:0] V6_INNER_SEQ_OFF = 8'd54;
	localparam logic [7:0] V6_MIN_LEN = 8'd8;
	localparam logic [7:0] V6_TE_MIN_LEN = 8'd56;

	typedef struct packed {
		logic [7:0]  pkt_byte;
		logic        last;
		logic [15:0] seq;
	} item_t;

	typedef struct packed {
		logic        ip_version;
		logic [15:0] probe_ident;
	} cfg_t;

endpackage

// ===== rtl/core/icmp_probe_reply_classifier_top.sv =====
// ----------------------------------------------------------------------------
// ICMP probe reply classifier
// Matches received packets against the outstanding traceroute probe.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle with no gaps needed between bytes or
// packets. Each byte is registered, then position tracking, field capture and
// classification compute the reply kind combinationally into the result
// register. The only stall is a final byte waiting while the previous result
// has not been taken. Registers (ip_version, probe_ident) must be written by
// the user only while no packet is in flight; the block does not enforce it.
`include "icmp_probe_reply_classifier_top_assert.svh"

module icmp_probe_reply_classifier_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [icmp_prc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         packet_byte,
	input  logic                               last_byte,
	input  logic [15:0]                        expected_seq,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         reply_kind
);
	import icmp_prc_pkg::*;

	cfg_t        cfg_q;
	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	reply_kind_t kind;
	reply_kind_t reply_kind_q;
	logic        out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_IP_VERSION:  cfg_q.ip_version <= cfg_data[0];
				REG_PROBE_IDENT: cfg_q.probe_ident <= cfg_data;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// A non-final byte always moves on; a final one needs a free result slot
	assign advance = valid_s1 && (!item_s1.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.pkt_byte <= packet_byte;
			item_s1.last <= last_byte;
			item_s1.seq <= expected_seq;
		end
	end

	icmp_prc_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.kind   (kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last) reply_kind_q <= kind;
	end

	assign out_valid = out_valid_q;
	assign reply_kind = reply_kind_q;

	`ICMP_PRC_ASSERT_NEXT(a_last_gives_result, advance && item_s1.last, out_valid, "final byte gave no result")
	`ICMP_PRC_ASSERT_NOW(a_stall_only_on_full, !in_ready, valid_s1 && item_s1.last && out_valid && !out_ready, "input stalled without a full result slot")
	`ICMP_PRC_ASSERT_NEXT(a_result_drains, out_valid && out_ready && !(advance && item_s1.last), !out_valid, "taken result not dropped")

endmodule

// ===== rtl/core/icmp_prc_parse.sv =====
// ----------------------------------------------------------------------------
// ICMP probe reply classifier field capture
// Tracks the byte position, captures header fields at fixed ICMPv6 offsets
// or IPv4 offsets from earlier bytes, and classifies the packet on its final byte.
// ----------------------------------------------------------------------------
module icmp_prc_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  icmp_prc_pkg::item_t       item,
	input  icmp_prc_pkg::cfg_t        cfg,
	output icmp_prc_pkg::reply_kind_t kind
);
	import icmp_prc_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [5:0]       ohl_q, ohl_n;
	logic [7:0]       type_q, type_n;
	logic [15:0]      ident_q, ident_n;
	logic [15:0]      seq_q, seq_n;
	logic [5:0]       ihl_q, ihl_n;
	logic [15:0]      iident_q, iident_n;
	logic [15:0]      iseq_q, iseq_n;

	logic             store;
	logic [CNT_W-1:0] len;
	logic [7:0]       b;
	logic [7:0]       ebase, inner, ibase;

	always_comb begin
		b = item.pkt_byte;
		store = cnt_q < CNT_W'(MAX_PACKET_BYTES);
		ohl_n = ohl_q;
		type_n = type_q;
		ident_n = ident_q;
		seq_n = seq_q;
		ihl_n = ihl_q;
		iident_n = iident_q;
		iseq_n = iseq_q;
		ebase = 8'd0;
		inner = 8'd0;
		ibase = 8'd0;
		if (store) begin
			if (!cfg.ip_version) begin
				if (cnt_q == '0) ohl_n = {b[3:0], 2'b00};
				if (cnt_q == CNT_W'({2'b00, ohl_n})) type_n = b;
				ebase = {2'b00, ohl_n} + 8'd4;
				if (cnt_q == CNT_W'(ebase)) ident_n[15:8] = b;
				if (cnt_q == CNT_W'(ebase + 8'd1)) ident_n[7:0] = b;
				if (cnt_q == CNT_W'(ebase + 8'd2)) seq_n[15:8] = b;
				if (cnt_q == CNT_W'(ebase + 8'd3)) seq_n[7:0] = b;
				inner = {2'b00, ohl_n} + 8'd8;
				if (cnt_q == CNT_W'(inner)) ihl_n = {b[3:0], 2'b00};
				ibase = inner + {2'b00, ihl_n} + 8'd4;
				if (cnt_q == CNT_W'(ibase)) iident_n[15:8] = b;
				if (cnt_q == CNT_W'(ibase + 8'd1)) iident_n[7:0] = b;
				if (cnt_q == CNT_W'(ibase + 8'd2)) iseq_n[15:8] = b;
				if (cnt_q == CNT_W'(ibase + 8'd3)) iseq_n[7:0] = b;
			end else begin
				if (cnt_q == '0) type_n = b;
				if (cnt_q == CNT_W'(V6_IDENT_OFF)) ident_n[15:8] = b;
				if (cnt_q == CNT_W'(V6_IDENT_OFF + 8'd1)) ident_n[7:0] = b;
				if (cnt_q == CNT_W'(V6_SEQ_OFF)) seq_n[15:8] = b;
				if (cnt_q == CNT_W'(V6_SEQ_OFF + 8'd1)) seq_n[7:0] = b;
				if (cnt_q == CNT_W'(V6_INNER_IDENT_OFF)) iident_n[15:8] = b;
				if (cnt_q == CNT_W'(V6_INNER_IDENT_OFF + 8'd1)) iident_n[7:0] = b;
				if (cnt_q == CNT_W'(V6_INNER_SEQ_OFF)) iseq_n[15:8] = b;
				if (cnt_q == CNT_W'(V6_INNER_SEQ_OFF + 8'd1)) iseq_n[7:0] = b;
			end
		end
		len = store ? cnt_q + CNT_W'(1) : cnt_q;
	end

	// Classify with the fields as they stand after this byte
	always_comb begin
		kind = KIND_NONE;
		if (!cfg.ip_version) begin
			if (len >= CNT_W'({2'b00, ohl_n} + 8'd8)) begin
				if (type_n == V4_ECHO_REPLY) begin
					if (ident_n == cfg.probe_ident && seq_n == item.seq) kind = KIND_DEST;
				end else if (type_n == V4_TIME_EXCEEDED) begin
					if (len >= CNT_W'({2'b00, ohl_n} + 8'd16 + {2'b00, ihl_n}) &&
					    iident_n == cfg.probe_ident && iseq_n == item.seq)
						kind = KIND_HOP;
				end
			end
		end else begin
			if (len >= CNT_W'(V6_MIN_LEN)) begin
				if (type_n == V6_ECHO_REPLY) begin
					if (ident_n == cfg.probe_ident && seq_n == item.seq) kind = KIND_DEST;
				end else if (type_n == V6_TIME_EXCEEDED) begin
					if (len >= CNT_W'(V6_TE_MIN_LEN) &&
					    iident_n == cfg.probe_ident && iseq_n == item.seq)
						kind = KIND_HOP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ohl_q <= '0;
			type_q <= '0;
			ident_q <= '0;
			seq_q <= '0;
			ihl_q <= '0;
			iident_q <= '0;
			iseq_q <= '0;
		end else if (step) begin
			if (item.last) begin
				// drop all packet state for the next packet
				cnt_q <= '0;
				ohl_q <= '0;
				type_q <= '0;
				ident_q <= '0;
				seq_q <= '0;
				ihl_q <= '0;
				iident_q <= '0;
				iseq_q <= '0;
			end else begin
				cnt_q <= len;
				ohl_q <= ohl_n;
				type_q <= type_n;
				ident_q <= ident_n;
				seq_q <= seq_n;
				ihl_q <= ihl_n;
				iident_q <= iident_n;
				iseq_q <= iseq_n;
			end
		end
	end

endmodule
